@@ rtl/ownership_lease_tracker_unit_defines.svh @@
// Assertion macros used by the lease tracker port checker.
`ifndef OWNERSHIP_LEASE_TRACKER_UNIT_DEFINES_SVH
`define OWNERSHIP_LEASE_TRACKER_UNIT_DEFINES_SVH

// Property checked at every edge, reset included.
`define OLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only outside reset.
`define OLT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/olt_pkg.sv @@
// Types and codes for the ownership lease tracker.
package olt_pkg;

  typedef enum logic [3:0] {
    CMD_BEGIN_ACQ    = 4'd0,
    CMD_COMP_ACQ     = 4'd1,
    CMD_BEGIN_RENEW  = 4'd2,
    CMD_COMP_RENEW   = 4'd3,
    CMD_BEGIN_REL    = 4'd4,
    CMD_COMP_REL     = 4'd5,
    CMD_CANCEL       = 4'd6,
    CMD_EXPIRE       = 4'd7,
    CMD_INVALIDATE   = 4'd8,
    CMD_QUERY_ACTIVE = 4'd9,
    CMD_QUERY_LEASE  = 4'd10,
    CMD_QUERY_PEND   = 4'd11
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_INVALID   = 4'd1,
    ST_CONFLICT  = 4'd2,
    ST_PRECOND   = 4'd3,
    ST_UNAUTH    = 4'd4,
    ST_DEADLINE  = 4'd5,
    ST_UNAVAIL   = 4'd6,
    ST_EXHAUSTED = 4'd7,
    ST_NONE      = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    KIND_ACQ   = 2'd0,
    KIND_RENEW = 2'd1,
    KIND_REL   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [63:0] now_ns;
    logic [63:0] time_value;
    logic [63:0] identity;
    logic [1:0]  echo_kind;
    logic [63:0] echo_id;
    logic [63:0] echo_generation;
    logic [63:0] echo_epoch;
    logic        confirmed;
    logic [63:0] reply_epoch;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  out_kind;
    logic [63:0] out_id;
    logic [63:0] out_generation;
    logic [63:0] out_epoch;
    logic [63:0] out_deadline;
    logic [63:0] out_identity;
    logic [63:0] lease_epoch_out;
    logic [63:0] lease_expiry_out;
  } rsp_t;

endpackage

@@ rtl/olt_req_if.sv @@
// Command channel interface of the lease tracker.
interface olt_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [63:0] now_ns;
  logic [63:0] time_value;
  logic [63:0] identity;
  logic [1:0]  echo_kind;
  logic [63:0] echo_id;
  logic [63:0] echo_generation;
  logic [63:0] echo_epoch;
  logic        confirmed;
  logic [63:0] reply_epoch;

  modport source (
    output valid, command, now_ns, time_value, identity, echo_kind, echo_id,
           echo_generation, echo_epoch, confirmed, reply_epoch,
    input  ready
  );
  modport sink (
    input  valid, command, now_ns, time_value, identity, echo_kind, echo_id,
           echo_generation, echo_epoch, confirmed, reply_epoch,
    output ready
  );
  modport mon (
    input valid, ready, command, now_ns, time_value, identity, echo_kind, echo_id,
          echo_generation, echo_epoch, confirmed, reply_epoch
  );
endinterface

@@ rtl/olt_rsp_if.sv @@
// Result channel interface of the lease tracker.
interface olt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [1:0]  out_kind;
  logic [63:0] out_id;
  logic [63:0] out_generation;
  logic [63:0] out_epoch;
  logic [63:0] out_deadline;
  logic [63:0] out_identity;
  logic [63:0] lease_epoch_out;
  logic [63:0] lease_expiry_out;

  modport source (
    output valid, status, out_kind, out_id, out_generation, out_epoch, out_deadline,
           out_identity, lease_epoch_out, lease_expiry_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_kind, out_id, out_generation, out_epoch, out_deadline,
           out_identity, lease_epoch_out, lease_expiry_out,
    output ready
  );
  modport mon (
    input valid, ready, status, out_kind, out_id, out_generation, out_epoch,
          out_deadline, out_identity, lease_epoch_out, lease_expiry_out
  );
endinterface

@@ rtl/olt_core.sv @@
// Lease and pending-operation state with the per-command decision logic.
module olt_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  olt_pkg::req_t  req,
  output olt_pkg::rsp_t  rsp
);
  import olt_pkg::*;

  logic        pend_valid, pend_valid_next;
  logic [1:0]  pend_kind, pend_kind_next;
  logic [63:0] pend_id, pend_id_next;
  logic [63:0] pend_gen, pend_gen_next;
  logic [63:0] pend_identity, pend_identity_next;
  logic [63:0] pend_epoch, pend_epoch_next;
  logic [63:0] pend_deadline, pend_deadline_next;
  logic        lease_valid, lease_valid_next;
  logic [63:0] lease_identity, lease_identity_next;
  logic [63:0] lease_epoch, lease_epoch_next;
  logic [63:0] lease_expiry, lease_expiry_next;
  logic [63:0] next_id, next_id_next;
  logic [63:0] cur_generation, cur_generation_next;

  logic [64:0] deadline_sum;
  logic        exhausted;
  logic [63:0] gen_inc;
  logic [63:0] gen_adv;
  logic        match_base;
  logic        reply_late;
  logic        launch;
  logic        show_pend;
  logic        show_lease;
  kind_t       launch_kind;
  logic [63:0] launch_identity;
  logic [63:0] launch_epoch;

  function automatic logic ident_ok(input logic [63:0] v);
    return (|v[15:0]) && (|v[31:16]) && (|v[47:32]) && (|v[63:48]);
  endfunction

  assign deadline_sum = {1'b0, req.now_ns} + {1'b0, req.time_value};
  assign exhausted    = (next_id == 64'd0) || (&next_id) || deadline_sum[64];
  assign gen_inc      = cur_generation + 64'd1;
  assign gen_adv      = (gen_inc == 64'd0) ? 64'd1 : gen_inc;
  assign reply_late   = req.time_value <= req.now_ns;
  assign match_base   = pend_valid && (pend_kind == req.echo_kind) &&
                        (pend_id == req.echo_id) && (pend_gen == req.echo_generation) &&
                        (pend_identity == req.identity) && (pend_epoch == req.echo_epoch);

  always_comb begin
    pend_valid_next     = pend_valid;
    lease_valid_next    = lease_valid;
    lease_identity_next = lease_identity;
    lease_epoch_next    = lease_epoch;
    lease_expiry_next   = lease_expiry;
    cur_generation_next = cur_generation;
    launch          = 1'b0;
    show_pend       = 1'b0;
    show_lease      = 1'b0;
    launch_kind     = KIND_ACQ;
    launch_identity = req.identity;
    launch_epoch    = 64'd0;
    rsp             = '0;
    rsp.status      = ST_OK;

    case (cmd_t'(req.command))
      CMD_BEGIN_ACQ: begin
        if (!ident_ok(req.identity) || req.time_value == 64'd0) begin
          rsp.status = ST_INVALID;
        end else if (pend_valid || lease_valid) begin
          rsp.status = ST_CONFLICT;
        end else if (exhausted) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          launch = 1'b1;
        end
      end
      CMD_COMP_ACQ: begin
        if (!(match_base && req.echo_kind == KIND_ACQ)) begin
          rsp.status = ST_PRECOND;
        end else begin
          pend_valid_next = 1'b0;
          if (!req.confirmed) begin
            rsp.status = ST_UNAUTH;
          end else if (req.reply_epoch == 64'd0 || reply_late) begin
            rsp.status = ST_INVALID;
          end else begin
            lease_valid_next    = 1'b1;
            lease_identity_next = req.identity;
            lease_epoch_next    = req.reply_epoch;
            lease_expiry_next   = req.time_value;
          end
        end
      end
      CMD_BEGIN_RENEW: begin
        if (req.time_value == 64'd0 || pend_valid || !lease_valid ||
            lease_expiry <= req.now_ns) begin
          rsp.status = ST_PRECOND;
        end else if (exhausted) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          launch          = 1'b1;
          launch_kind     = KIND_RENEW;
          launch_identity = lease_identity;
          launch_epoch    = lease_epoch;
        end
      end
      CMD_COMP_RENEW: begin
        if (!(match_base && req.echo_kind == KIND_RENEW)) begin
          rsp.status = ST_PRECOND;
        end else begin
          pend_valid_next = 1'b0;
          if (!lease_valid || lease_identity != req.identity ||
              lease_epoch != req.echo_epoch || !req.confirmed ||
              req.reply_epoch != req.echo_epoch || reply_late) begin
            lease_valid_next = 1'b0;
            rsp.status       = ST_DEADLINE;
          end else begin
            lease_expiry_next = req.time_value;
          end
        end
      end
      CMD_BEGIN_REL: begin
        if (req.time_value == 64'd0 || pend_valid || !lease_valid) begin
          rsp.status = ST_PRECOND;
        end else begin
          // lease is dropped even when the begin runs out of ids or time
          lease_valid_next = 1'b0;
          if (exhausted) begin
            rsp.status = ST_EXHAUSTED;
          end else begin
            launch          = 1'b1;
            launch_kind     = KIND_REL;
            launch_identity = lease_identity;
            launch_epoch    = lease_epoch;
          end
        end
      end
      CMD_COMP_REL: begin
        if (!(match_base && req.echo_kind == KIND_REL)) begin
          rsp.status = ST_PRECOND;
        end else begin
          pend_valid_next = 1'b0;
          if (!req.confirmed) begin
            rsp.status = ST_UNAVAIL;
          end
        end
      end
      CMD_CANCEL: begin
        if (!pend_valid) begin
          rsp.status = ST_NONE;
        end else begin
          show_pend           = 1'b1;
          pend_valid_next     = 1'b0;
          cur_generation_next = gen_adv;
        end
      end
      CMD_EXPIRE: begin
        if (!pend_valid || pend_deadline > req.now_ns) begin
          rsp.status = ST_NONE;
        end else begin
          show_pend           = 1'b1;
          pend_valid_next     = 1'b0;
          cur_generation_next = gen_adv;
          if (pend_kind == KIND_RENEW) begin
            lease_valid_next = 1'b0;
          end
        end
      end
      CMD_INVALIDATE: begin
        lease_valid_next    = 1'b0;
        pend_valid_next     = 1'b0;
        cur_generation_next = gen_adv;
      end
      CMD_QUERY_ACTIVE: begin
        if (!lease_valid || lease_expiry <= req.now_ns) begin
          rsp.status = ST_NONE;
        end else begin
          show_lease = 1'b1;
        end
      end
      CMD_QUERY_LEASE: begin
        if (!lease_valid) begin
          rsp.status = ST_NONE;
        end else begin
          show_lease = 1'b1;
        end
      end
      CMD_QUERY_PEND: begin
        if (!pend_valid) begin
          rsp.status = ST_NONE;
        end else begin
          show_pend = 1'b1;
        end
      end
      default: begin
        rsp.status = ST_INVALID;
      end
    endcase

    if (launch) begin
      pend_valid_next    = 1'b1;
      pend_kind_next     = launch_kind;
      pend_id_next       = next_id;
      pend_gen_next      = cur_generation;
      pend_identity_next = launch_identity;
      pend_epoch_next    = launch_epoch;
      pend_deadline_next = deadline_sum[63:0];
      next_id_next       = next_id + 64'd1;
    end else begin
      pend_kind_next     = pend_kind;
      pend_id_next       = pend_id;
      pend_gen_next      = pend_gen;
      pend_identity_next = pend_identity;
      pend_epoch_next    = pend_epoch;
      pend_deadline_next = pend_deadline;
      next_id_next       = next_id;
    end

    // a fresh or reported operation is the one held after this command
    if (launch || show_pend) begin
      rsp.out_kind       = pend_kind_next;
      rsp.out_id         = pend_id_next;
      rsp.out_generation = pend_gen_next;
      rsp.out_epoch      = pend_epoch_next;
      rsp.out_deadline   = pend_deadline_next;
      rsp.out_identity   = pend_identity_next;
    end
    if (show_lease) begin
      rsp.out_identity     = lease_identity;
      rsp.lease_epoch_out  = lease_epoch;
      rsp.lease_expiry_out = lease_expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid     <= 1'b0;
      pend_kind      <= KIND_ACQ;
      pend_id        <= 64'd0;
      pend_gen       <= 64'd0;
      pend_identity  <= 64'd0;
      pend_epoch     <= 64'd0;
      pend_deadline  <= 64'd0;
      lease_valid    <= 1'b0;
      lease_identity <= 64'd0;
      lease_epoch    <= 64'd0;
      lease_expiry   <= 64'd0;
      next_id        <= 64'd1;
      cur_generation <= 64'd1;
    end else if (step) begin
      pend_valid     <= pend_valid_next;
      pend_kind      <= pend_kind_next;
      pend_id        <= pend_id_next;
      pend_gen       <= pend_gen_next;
      pend_identity  <= pend_identity_next;
      pend_epoch     <= pend_epoch_next;
      pend_deadline  <= pend_deadline_next;
      lease_valid    <= lease_valid_next;
      lease_identity <= lease_identity_next;
      lease_epoch    <= lease_epoch_next;
      lease_expiry   <= lease_expiry_next;
      next_id        <= next_id_next;
      cur_generation <= cur_generation_next;
    end
  end

endmodule

@@ rtl/ownership_lease_tracker_unit.sv @@
// A taken command is registered in the input register; its result is computed from
// that register and registered in the result register, which drives the result channel.
// Throughput: one command per cycle while results are not stalled; the input register and
// the result register each advance while the stage ahead is empty or draining.
// Reset (synchronous, rst high): both stages empty, no lease, no pending operation,
// next id and generation start at one.
module ownership_lease_tracker_unit (
  input logic     clk,
  input logic     rst,
  olt_req_if.sink req,
  olt_rsp_if.source rsp
);
  import olt_pkg::*;

  logic  in_valid;
  req_t  in_data;
  logic  out_valid;
  rsp_t  out_data;
  rsp_t  core_rsp;
  logic  advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  olt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (in_data),
    .rsp  (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (!out_valid || rsp.ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_data.command         <= req.command;
      in_data.now_ns          <= req.now_ns;
      in_data.time_value      <= req.time_value;
      in_data.identity        <= req.identity;
      in_data.echo_kind       <= req.echo_kind;
      in_data.echo_id         <= req.echo_id;
      in_data.echo_generation <= req.echo_generation;
      in_data.echo_epoch      <= req.echo_epoch;
      in_data.confirmed       <= req.confirmed;
      in_data.reply_epoch     <= req.reply_epoch;
    end
    if (advance) begin
      out_data <= core_rsp;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_data.status;
  assign rsp.out_kind         = out_data.out_kind;
  assign rsp.out_id           = out_data.out_id;
  assign rsp.out_generation   = out_data.out_generation;
  assign rsp.out_epoch        = out_data.out_epoch;
  assign rsp.out_deadline     = out_data.out_deadline;
  assign rsp.out_identity     = out_data.out_identity;
  assign rsp.lease_epoch_out  = out_data.lease_epoch_out;
  assign rsp.lease_expiry_out = out_data.lease_expiry_out;

endmodule

@@ rtl/olt_checker.sv @@
// Port-level checks for the lease tracker and their bind to the top level.
`include "ownership_lease_tracker_unit_defines.svh"

module olt_checker (
  input logic       clk,
  input logic       rst,
  olt_req_if.sink   req,
  olt_rsp_if.source rsp
);
  import olt_pkg::*;

  `OLT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp.valid,
    "result offered right after reset")
  `OLT_ASSERT(a_fresh_needs_cmd, clk, rst,
    $rose(rsp.valid) |-> $past(req.valid && req.ready, 2),
    "result without a command transaction two cycles earlier")
  `OLT_ASSERT(a_status_range, clk, rst, rsp.valid |-> (rsp.status <= ST_NONE),
    "status code out of range")
  `OLT_ASSERT(a_empty_fields, clk, rst,
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.out_id == 64'd0 &&
    rsp.out_identity == 64'd0 && rsp.lease_expiry_out == 64'd0),
    "failed command returned data")
  `OLT_ASSERT(a_rsp_hold, clk, rst, (rsp.valid && !rsp.ready) |=>
    (rsp.valid && $stable(rsp.status) && $stable(rsp.out_id)),
    "stalled result changed")

endmodule

bind ownership_lease_tracker_unit olt_checker u_olt_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

@@ sim/olt_lease_checker.sv @@
// Lease tracker checker: mirrors the tracker state, predicts each result and compares it.
`timescale 1ns / 100ps

module olt_lease_checker (
  input  logic           clk,
  input  logic           rst,
  olt_req_if.mon         req,
  olt_rsp_if.mon         rsp,
  output int             fails,
  output int             owed,
  output int             answers,
  output int             grants,
  output logic           op_open,
  output olt_pkg::kind_t op_kind,
  output logic [63:0]    op_id,
  output logic [63:0]    op_gen,
  output logic [63:0]    op_owner,
  output logic [63:0]    op_epoch,
  output logic [63:0]    op_due,
  output logic           lease_held,
  output logic [63:0]    lease_until
);
  import olt_pkg::*;

  logic [63:0] lease_owner;
  logic [63:0] lease_epoch;
  logic [63:0] id_next;
  logic [63:0] gen_now;
  rsp_t        owed_results[$];

  function automatic bit tags_complete(logic [63:0] v);
    return v[15:0] != '0 && v[31:16] != '0 && v[47:32] != '0 && v[63:48] != '0;
  endfunction

  function automatic void bump_gen();
    gen_now = gen_now + 64'd1;
    if (gen_now == '0) gen_now = 64'd1;
  endfunction

  function automatic rsp_t op_answer();
    rsp_t r;
    r                = '0;
    r.status         = ST_OK;
    r.out_kind       = op_kind;
    r.out_id         = op_id;
    r.out_generation = op_gen;
    r.out_epoch      = op_epoch;
    r.out_deadline   = op_due;
    r.out_identity   = op_owner;
    return r;
  endfunction

  function automatic rsp_t lease_answer();
    rsp_t r;
    r                  = '0;
    r.status           = ST_OK;
    r.out_identity     = lease_owner;
    r.lease_epoch_out  = lease_epoch;
    r.lease_expiry_out = lease_until;
    return r;
  endfunction

  // Opens a pending operation unless the id or the deadline runs out.
  function automatic status_t open_op(kind_t k, logic [63:0] owner, logic [63:0] ep,
                                      logic [63:0] now, logic [63:0] span);
    logic [64:0] due;
    due = {1'b0, now} + {1'b0, span};
    if (id_next == '0 || id_next == '1 || due[64]) return ST_EXHAUSTED;
    op_open  = 1'b1;
    op_kind  = k;
    op_id    = id_next;
    id_next  = id_next + 64'd1;
    op_gen   = gen_now;
    op_owner = owner;
    op_epoch = ep;
    op_due   = due[63:0];
    return ST_OK;
  endfunction

  function automatic bit echo_matches(kind_t k, req_t c);
    return c.echo_kind == k && op_open && op_kind == k && op_id == c.echo_id &&
           op_gen == c.echo_generation && op_owner == c.identity &&
           op_epoch == c.echo_epoch;
  endfunction

  function automatic rsp_t run_lease_command(req_t c);
    rsp_t r;
    r        = '0;
    r.status = ST_OK;
    case (c.command)
      CMD_BEGIN_ACQ: begin
        if (!tags_complete(c.identity) || c.time_value == '0) r.status = ST_INVALID;
        else if (op_open || lease_held) r.status = ST_CONFLICT;
        else begin
          r.status = open_op(KIND_ACQ, c.identity, '0, c.now_ns, c.time_value);
          if (r.status == ST_OK) r = op_answer();
        end
      end
      CMD_COMP_ACQ: begin
        if (!echo_matches(KIND_ACQ, c)) r.status = ST_PRECOND;
        else begin
          op_open = 1'b0;
          if (!c.confirmed) r.status = ST_UNAUTH;
          else if (c.reply_epoch == '0 || c.time_value <= c.now_ns) r.status = ST_INVALID;
          else begin
            lease_held  = 1'b1;
            lease_owner = c.identity;
            lease_epoch = c.reply_epoch;
            lease_until = c.time_value;
            grants++;
          end
        end
      end
      CMD_BEGIN_RENEW: begin
        if (c.time_value == '0 || op_open || !lease_held || lease_until <= c.now_ns) begin
          r.status = ST_PRECOND;
        end else begin
          r.status = open_op(KIND_RENEW, lease_owner, lease_epoch, c.now_ns, c.time_value);
          if (r.status == ST_OK) r = op_answer();
        end
      end
      CMD_COMP_RENEW: begin
        if (!echo_matches(KIND_RENEW, c)) r.status = ST_PRECOND;
        else begin
          op_open = 1'b0;
          if (!lease_held || lease_owner != c.identity || lease_epoch != c.echo_epoch ||
              !c.confirmed || c.reply_epoch != c.echo_epoch ||
              c.time_value <= c.now_ns) begin
            lease_held = 1'b0;
            r.status   = ST_DEADLINE;
          end else begin
            lease_until = c.time_value;
          end
        end
      end
      CMD_BEGIN_REL: begin
        if (c.time_value == '0 || op_open || !lease_held) r.status = ST_PRECOND;
        else begin
          // lease is dropped even if the begin runs out of ids or time
          lease_held = 1'b0;
          r.status = open_op(KIND_REL, lease_owner, lease_epoch, c.now_ns, c.time_value);
          if (r.status == ST_OK) r = op_answer();
        end
      end
      CMD_COMP_REL: begin
        if (!echo_matches(KIND_REL, c)) r.status = ST_PRECOND;
        else begin
          op_open = 1'b0;
          if (!c.confirmed) r.status = ST_UNAVAIL;
        end
      end
      CMD_CANCEL: begin
        if (!op_open) r.status = ST_NONE;
        else begin
          r       = op_answer();
          op_open = 1'b0;
          bump_gen();
        end
      end
      CMD_EXPIRE: begin
        if (!op_open || op_due > c.now_ns) r.status = ST_NONE;
        else begin
          r       = op_answer();
          op_open = 1'b0;
          if (op_kind == KIND_RENEW) lease_held = 1'b0;
          bump_gen();
        end
      end
      CMD_INVALIDATE: begin
        lease_held = 1'b0;
        op_open    = 1'b0;
        bump_gen();
      end
      CMD_QUERY_ACTIVE: begin
        if (!lease_held || lease_until <= c.now_ns) r.status = ST_NONE;
        else r = lease_answer();
      end
      CMD_QUERY_LEASE: begin
        if (!lease_held) r.status = ST_NONE;
        else r = lease_answer();
      end
      CMD_QUERY_PEND: begin
        if (!op_open) r.status = ST_NONE;
        else r = op_answer();
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    req_t taken;
    rsp_t want;
    if (rst) begin
      op_open     = 1'b0;
      op_kind     = KIND_ACQ;
      op_id       = '0;
      op_gen      = '0;
      op_owner    = '0;
      op_epoch    = '0;
      op_due      = '0;
      lease_held  = 1'b0;
      lease_owner = '0;
      lease_epoch = '0;
      lease_until = '0;
      id_next     = 64'd1;
      gen_now     = 64'd1;
      owed_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          fails++;
        end else begin
          want = owed_results.pop_front();
          answers++;
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("out_kind", 64'(want.out_kind), 64'(rsp.out_kind));
          check_field("out_id", want.out_id, rsp.out_id);
          check_field("out_generation", want.out_generation, rsp.out_generation);
          check_field("out_epoch", want.out_epoch, rsp.out_epoch);
          check_field("out_deadline", want.out_deadline, rsp.out_deadline);
          check_field("out_identity", want.out_identity, rsp.out_identity);
          check_field("lease_epoch_out", want.lease_epoch_out, rsp.lease_epoch_out);
          check_field("lease_expiry_out", want.lease_expiry_out, rsp.lease_expiry_out);
        end
      end
      if (req.valid && req.ready) begin
        taken.command         = req.command;
        taken.now_ns          = req.now_ns;
        taken.time_value      = req.time_value;
        taken.identity        = req.identity;
        taken.echo_kind       = req.echo_kind;
        taken.echo_id         = req.echo_id;
        taken.echo_generation = req.echo_generation;
        taken.echo_epoch      = req.echo_epoch;
        taken.confirmed       = req.confirmed;
        taken.reply_epoch     = req.reply_epoch;
        owed_results.push_back(run_lease_command(taken));
      end
    end
    owed = owed_results.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives commands and result back-pressure into the lease tracker.
`timescale 1ns / 100ps

module tb;
  import olt_pkg::*;

  localparam logic [3:0] FIRST_UNUSED_CMD = CMD_QUERY_PEND + 4'd1;
  localparam logic [3:0] LAST_UNUSED_CMD  = 4'hF;
  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam int         CMD_TOTAL        = 1575;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          fails;
  int          owed;
  int          answers;
  int          grants;
  logic        op_open;
  kind_t       op_kind;
  logic [63:0] op_id;
  logic [63:0] op_gen;
  logic [63:0] op_owner;
  logic [63:0] op_epoch;
  logic [63:0] op_due;
  logic        lease_held;
  logic [63:0] lease_until;
  bit          calm = 1'b0;
  logic [63:0] wall_ns = 64'd1000;
  int          sent = 0;
  int          directed;

  olt_req_if req_ch();
  olt_rsp_if rsp_ch();

  ownership_lease_tracker_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  olt_lease_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fails       (fails),
    .owed        (owed),
    .answers     (answers),
    .grants      (grants),
    .op_open     (op_open),
    .op_kind     (op_kind),
    .op_id       (op_id),
    .op_gen      (op_gen),
    .op_owner    (op_owner),
    .op_epoch    (op_epoch),
    .op_due      (op_due),
    .lease_held  (lease_held),
    .lease_until (lease_until)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int idle_cycles();
    if (calm) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [63:0] any64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] one_bit();
    return 64'd1 << $urandom_range(0, 63);
  endfunction

  function automatic logic [63:0] good_tags();
    return {16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
            16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF))};
  endfunction

  function automatic req_t blank(cmd_t k);
    req_t c;
    c         = '0;
    c.command = k;
    c.now_ns  = wall_ns;
    return c;
  endfunction

  function automatic req_t any_query();
    case ($urandom_range(0, 2))
      0:       return blank(CMD_QUERY_ACTIVE);
      1:       return blank(CMD_QUERY_LEASE);
      default: return blank(CMD_QUERY_PEND);
    endcase
  endfunction

  // Completion that echoes the open operation as the partner would.
  function automatic req_t echo_op(cmd_t k, bit conf, logic [63:0] reply,
                                   logic [63:0] expiry);
    req_t c;
    c                 = blank(k);
    c.echo_kind       = op_kind;
    c.echo_id         = op_id;
    c.echo_generation = op_gen;
    c.identity        = op_owner;
    c.echo_epoch      = op_epoch;
    c.confirmed       = conf;
    c.reply_epoch     = reply;
    c.time_value      = expiry;
    return c;
  endfunction

  function automatic req_t spoil_echo(req_t c);
    case ($urandom_range(0, 4))
      0:       c.echo_kind = $urandom_range(0, 1) ? KIND_UNUSED : c.echo_kind + 2'd1;
      1:       c.echo_id ^= one_bit();
      2:       c.echo_generation ^= one_bit();
      3:       c.identity ^= one_bit();
      default: c.echo_epoch ^= one_bit();
    endcase
    return c;
  endfunction

  function automatic req_t noise_item();
    req_t c;
    c.command         = 4'($urandom_range(0, 15));
    c.now_ns          = $urandom_range(0, 1) ? any64() : wall_ns;
    c.time_value      = any64();
    c.identity        = any64();
    c.echo_kind       = 2'($urandom_range(0, 3));
    c.echo_id         = any64();
    c.echo_generation = any64();
    c.echo_epoch      = any64();
    c.confirmed       = 1'($urandom_range(0, 1));
    c.reply_epoch     = any64();
    if (op_open && $urandom_range(0, 1)) begin
      c.echo_kind       = op_kind;
      c.echo_id         = op_id;
      c.echo_generation = op_gen;
      c.identity        = op_owner;
      c.echo_epoch      = op_epoch;
    end
    return c;
  endfunction

  function automatic req_t pick_item();
    req_t        c;
    cmd_t        k;
    int          roll;
    logic [63:0] reply;
    logic [63:0] expiry;
    if ($urandom_range(0, 99) < 12) return noise_item();
    roll = $urandom_range(0, 99);
    if (op_open) begin
      if (roll < 65) begin
        case (op_kind)
          KIND_ACQ:   k = CMD_COMP_ACQ;
          KIND_RENEW: k = CMD_COMP_RENEW;
          default:    k = CMD_COMP_REL;
        endcase
        reply = (op_kind == KIND_ACQ) ? any64() : op_epoch;
        if ($urandom_range(0, 19) == 0) reply = (op_kind == KIND_ACQ) ? '0 : reply ^ one_bit();
        expiry = wall_ns + $urandom_range(1, 400);
        if ($urandom_range(0, 11) == 0) expiry = wall_ns - $urandom_range(0, 5);
        c = echo_op(k, $urandom_range(0, 9) != 0, reply, expiry);
        if ($urandom_range(0, 7) == 0) c = spoil_echo(c);
      end else if (roll < 75) begin
        c = blank(CMD_EXPIRE);
        c.now_ns = $urandom_range(0, 1) ? op_due + $urandom_range(0, 3) : op_due - 64'd1;
      end else if (roll < 82) c = blank(CMD_CANCEL);
      else if (roll < 85) c = blank(CMD_INVALIDATE);
      else c = any_query();
    end else if (lease_held) begin
      if (roll < 45) begin
        c = blank(CMD_BEGIN_RENEW);
        c.time_value = 64'($urandom_range(1, 300));
      end else if (roll < 65) begin
        c = blank(CMD_BEGIN_REL);
        c.time_value = $urandom_range(0, 30) == 0 ? '0 : 64'($urandom_range(1, 300));
      end else if (roll < 88) c = any_query();
      else if (roll < 92) c = blank(CMD_INVALIDATE);
      else if (roll < 96) begin
        c = blank(CMD_BEGIN_ACQ);
        c.identity   = good_tags();
        c.time_value = 64'($urandom_range(1, 300));
      end else c = blank($urandom_range(0, 1) ? CMD_CANCEL : CMD_EXPIRE);
    end else begin
      if (roll < 80) begin
        c = blank(CMD_BEGIN_ACQ);
        c.identity   = good_tags();
        c.time_value = 64'($urandom_range(1, 300));
        roll = $urandom_range(0, 99);
        if (roll < 3) c.time_value = '0;
        else if (roll < 6) c.identity[16*$urandom_range(0, 3) +: 16] = '0;
        else if (roll < 8) c.time_value = '1;
      end else if (roll < 94) c = any_query();
      else c = blank($urandom_range(0, 1) ? CMD_CANCEL : CMD_EXPIRE);
    end
    return c;
  endfunction

  task automatic present(input req_t c);
    req_ch.command         <= c.command;
    req_ch.now_ns          <= c.now_ns;
    req_ch.time_value      <= c.time_value;
    req_ch.identity        <= c.identity;
    req_ch.echo_kind       <= c.echo_kind;
    req_ch.echo_id         <= c.echo_id;
    req_ch.echo_generation <= c.echo_generation;
    req_ch.echo_epoch      <= c.echo_epoch;
    req_ch.confirmed       <= c.confirmed;
    req_ch.reply_epoch     <= c.reply_epoch;
  endtask

  // Entered and left at a falling edge; returns once the transaction is taken.
  task automatic push_cmd(input req_t c);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    present(c);
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  task automatic push_plain(input cmd_t k);
    push_cmd(blank(k));
  endtask

  task automatic open_and_grant(input logic [63:0] ep, input logic [63:0] expiry);
    req_t c;
    c = blank(CMD_BEGIN_ACQ);
    c.identity   = good_tags();
    c.time_value = 64'd20;
    push_cmd(c);
    push_cmd(echo_op(CMD_COMP_ACQ, 1'b1, ep, expiry));
  endtask

  initial begin : results_side
    int stall;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
    end
  end

  initial begin : commands_side
    req_t c;
    req_ch.valid <= 1'b0;
    present('0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_plain(CMD_QUERY_PEND);
    push_plain(CMD_QUERY_LEASE);
    push_plain(CMD_CANCEL);
    push_plain(CMD_EXPIRE);
    c = blank(CMD_BEGIN_ACQ);
    c.identity   = 64'hFFFF_FFFF_0000_FFFF;
    c.time_value = 64'd10;
    push_cmd(c);
    c.identity   = '1;
    c.time_value = '0;
    push_cmd(c);
    c.now_ns     = '1;
    c.time_value = 64'd1;
    push_cmd(c);
    c.now_ns     = 64'd100;
    c.time_value = 64'd50;
    push_cmd(c);
    push_cmd(c);
    c = echo_op(CMD_COMP_ACQ, 1'b1, '1, '1);
    c.echo_kind = KIND_UNUSED;
    push_cmd(c);
    push_cmd(echo_op(CMD_COMP_ACQ, 1'b1, '1, '1));
    push_plain(CMD_QUERY_ACTIVE);
    c = blank(CMD_BEGIN_RENEW);
    c.time_value = 64'd100;
    push_cmd(c);
    c = blank(CMD_EXPIRE);
    c.now_ns = op_due;
    push_cmd(c);
    push_plain(CMD_QUERY_LEASE);
    open_and_grant(64'd5, wall_ns + 64'd1000);
    c = blank(CMD_BEGIN_REL);
    c.now_ns     = '1;
    c.time_value = '1;
    push_cmd(c);
    push_plain(CMD_QUERY_LEASE);
    c = blank(CMD_BEGIN_ACQ);
    c.identity   = good_tags();
    c.time_value = 64'd30;
    push_cmd(c);
    push_cmd(echo_op(CMD_COMP_ACQ, 1'b0, 64'd7, wall_ns + 64'd500));
    push_cmd(c);
    push_plain(CMD_CANCEL);
    c = blank(CMD_INVALIDATE);
    c.command = FIRST_UNUSED_CMD;
    push_cmd(c);
    c.command = LAST_UNUSED_CMD;
    push_cmd(c);
    push_plain(CMD_INVALIDATE);
    directed = sent;

    while (sent < CMD_TOTAL) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      wall_ns = wall_ns + $urandom_range(0, 40);
      push_cmd(pick_item());
    end
    req_ch.valid <= 1'b0;

    while (owed != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Issued %0d commands (%0d directed), checked %0d results, %0d leases granted.",
             sent, directed, answers, grants);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/olt_pkg.sv
rtl/olt_req_if.sv
rtl/olt_rsp_if.sv
rtl/olt_core.sv
rtl/ownership_lease_tracker_unit.sv
rtl/olt_checker.sv
sim/olt_lease_checker.sv
sim/tb.sv
